// File: rtl/typed_message_fifo_unit_defines.svh
// Assertion macros for the typed message FIFO unit checker
`ifndef TYPED_MESSAGE_FIFO_UNIT_DEFINES_SVH
`define TYPED_MESSAGE_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmf check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmf check failed");

`endif

// File: rtl/tmf_pkg.sv
// Shared types, sizes and helpers of the typed message FIFO unit
`default_nettype none
package tmf_pkg;

  localparam int MSG_TYPES   = 16;
  localparam int QUEUE_DEPTH = 64;
  localparam int ID_W        = 4;
  localparam int HND_W       = 32;
  localparam int PRM_W       = 32;
  localparam int ENTRY_W     = ID_W + PRM_W;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_REG  = 2'd0,
    REQ_POST = 2'd1,
    REQ_GET  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_SLOT = 3'd1,
    ST_BAD_ID  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic             wr_en;
    logic [HND_W-1:0] wr_handler;
    logic             rd_en;
    logic [ID_W-1:0]  rd_id;
    logic [ID_W-1:0]  chk_id;
  } slot_ctrl_t;

  typedef struct packed {
    logic            free_found;
    logic [ID_W-1:0] free_slot;
    logic            chk_valid;
  } slot_stat_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage
`default_nettype wire

// File: rtl/tmf_if.sv
// Request and response channel interfaces of the typed message FIFO unit
`default_nettype none
interface tmf_req_if import tmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [HND_W-1:0] handler;
  logic [ID_W-1:0]  msg_id;
  logic [PRM_W-1:0] param;

  modport source (output valid, req_type, handler, msg_id, param, input ready);
  modport sink (input valid, req_type, handler, msg_id, param, output ready);
endinterface

interface tmf_rsp_if import tmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [ID_W-1:0]  out_id;
  logic [HND_W-1:0] out_handler;
  logic [PRM_W-1:0] out_param;

  modport source (output valid, status, out_id, out_handler, out_param, input ready);
  modport sink (input valid, status, out_id, out_handler, out_param, output ready);
endinterface
`default_nettype wire

// File: rtl/tmf_slot_table.sv
// Type slot table: valid bits, lowest free slot search and handler memory
`default_nettype none
module tmf_slot_table import tmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slot_ctrl_t       ctrl_i,
  output slot_stat_t       stat_o,
  output logic [HND_W-1:0] rdata_o
);

  logic [MSG_TYPES-1:0] valid_q;
  logic [HND_W-1:0]     hnd_mem [MSG_TYPES];
  logic [HND_W-1:0]     rdata_q;

  always_comb begin
    stat_o.free_found = 1'b0;
    stat_o.free_slot  = '0;
    for (int i = MSG_TYPES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        stat_o.free_found = 1'b1;
        stat_o.free_slot  = ID_W'(i);
      end
    end
    stat_o.chk_valid = valid_q[ctrl_i.chk_id];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.wr_en) begin
      valid_q[stat_o.free_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      hnd_mem[stat_o.free_slot] <= ctrl_i.wr_handler;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= hnd_mem[ctrl_i.rd_id];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/typed_message_fifo_unit.sv
// Top level of the typed message FIFO unit: request decode, message ring and response register
//
// Register, post and malformed requests, and a get from an empty ring, are answered
// from the idle state: the word is loaded into the response register at the next
// edge and a new request word is taken every cycle as long as the response
// register drains. A get from a non-empty ring does two dependent synchronous
// memory reads: the ring entry on acceptance, then in S_QRD the handler memory at
// the id found in that entry; S_HRD loads the response register once it is free.
// The ring holds up to 64 messages; the type slot valid bits clear at reset, so no
// clearing pass is needed and requests are taken right after reset.
`default_nettype none
module typed_message_fifo_unit import tmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmf_req_if.sink   req_i,
  tmf_rsp_if.source rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_QRD  = 2'd1;
  localparam logic [1:0] S_HRD  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [ENTRY_W-1:0] q_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] q_rdata_q;
  logic               q_we, q_re;

  slot_ctrl_t       slot_ctrl;
  slot_stat_t       slot_stat;
  logic [HND_W-1:0] slot_rdata;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [ID_W-1:0]  out_id_q, out_id_d;
  logic [HND_W-1:0] out_hnd_q, out_hnd_d;
  logic [PRM_W-1:0] out_prm_q, out_prm_d;
  logic             out_load;
  logic             out_free;
  logic             in_acc;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc      = req_i.valid && req_i.ready;

  tmf_slot_table u_slot_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (slot_ctrl),
    .stat_o  (slot_stat),
    .rdata_o (slot_rdata)
  );

  always_comb begin
    state_d      = state_q;
    wptr_d       = wptr_q;
    rptr_d       = rptr_q;
    count_d      = count_q;
    q_we         = 1'b0;
    q_re         = 1'b0;
    slot_ctrl    = '0;
    slot_ctrl.wr_handler = req_i.handler;
    slot_ctrl.chk_id     = req_i.msg_id;
    slot_ctrl.rd_id      = q_rdata_q[ENTRY_W-1:PRM_W];
    out_load     = 1'b0;
    out_status_d = ST_OK;
    out_id_d     = '0;
    out_hnd_d    = '0;
    out_prm_d    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_i.req_type)
            REQ_REG: begin
              out_load = 1'b1;
              if (req_i.handler != '0 && slot_stat.free_found) begin
                slot_ctrl.wr_en = 1'b1;
                out_id_d        = slot_stat.free_slot;
              end else begin
                out_status_d = ST_NO_SLOT;
              end
            end
            REQ_POST: begin
              out_load = 1'b1;
              if (!slot_stat.chk_valid) begin
                out_status_d = ST_BAD_ID;
              end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                out_status_d = ST_FULL;
              end else begin
                q_we    = 1'b1;
                wptr_d  = ring_next(wptr_q);
                count_d = count_q + 1'b1;
              end
            end
            REQ_GET: begin
              if (count_q == '0) begin
                out_load     = 1'b1;
                out_status_d = ST_EMPTY;
              end else begin
                q_re    = 1'b1;
                rptr_d  = ring_next(rptr_q);
                count_d = count_q - 1'b1;
                state_d = S_QRD;
              end
            end
            default: begin
              out_load     = 1'b1;
              out_status_d = ST_BAD_ID;
            end
          endcase
        end
      end
      S_QRD: begin
        slot_ctrl.rd_en = 1'b1;
        state_d         = S_HRD;
      end
      S_HRD: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_id_d  = q_rdata_q[ENTRY_W-1:PRM_W];
          out_hnd_d = slot_rdata;
          out_prm_d = q_rdata_q[PRM_W-1:0];
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_hnd_q    <= out_hnd_d;
      out_prm_q    <= out_prm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[wptr_q] <= {req_i.msg_id, req_i.param};
    end
    if (q_re) begin
      q_rdata_q <= q_mem[rptr_q];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_id      = out_id_q;
  assign rsp_o.out_handler = out_hnd_q;
  assign rsp_o.out_param   = out_prm_q;

endmodule
`default_nettype wire

// File: rtl/tmf_checker.sv
// Port-level checker of the typed message FIFO unit and its bind
`default_nettype none
`include "typed_message_fifo_unit_defines.svh"

module tmf_checker import tmf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic [1:0]       req_type_i,
  input logic [HND_W-1:0] handler_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [2:0]       status_i,
  input logic [ID_W-1:0]  out_id_i,
  input logic [HND_W-1:0] out_handler_i,
  input logic [PRM_W-1:0] out_param_i
);

  logic req_acc;
  logic zero_reg_acc;
  logic rsp_empty;
  logic rsp_fields_zero;

  assign req_acc         = req_valid_i && req_ready_i;
  assign zero_reg_acc    = req_acc && req_type_i == REQ_REG && handler_i == '0;
  assign rsp_empty       = rsp_valid_i && status_i == ST_EMPTY;
  assign rsp_fields_zero = out_id_i == '0 && out_handler_i == '0 && out_param_i == '0;

  `TMF_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `TMF_ASSERT_NXT(a_short_req_answered, req_acc && req_type_i != REQ_GET, rsp_valid_i)
  `TMF_ASSERT_NXT(a_zero_handler_rejected, zero_reg_acc, status_i == ST_NO_SLOT)
  `TMF_ASSERT_IMP(a_empty_fields_zero, rsp_empty, rsp_fields_zero)

endmodule

bind typed_message_fifo_unit tmf_checker u_tmf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_type_i    (req_i.req_type),
  .handler_i     (req_i.handler),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .out_id_i      (rsp_o.out_id),
  .out_handler_i (rsp_o.out_handler),
  .out_param_i   (rsp_o.out_param)
);
`default_nettype wire
